### rtl/rtbg_pkg.sv
// Shared types and register codes for the ramped tone burst generator.
// No dependencies; rtbg_serial_mul, rtbg_serial_div and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package rtbg_pkg;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INDEX,
        ST_ROM,
        ST_AMP,
        ST_CHK_UP,
        ST_UP_MUL,
        ST_UP_DIV,
        ST_CHK_DN,
        ST_DN_MUL,
        ST_DN_DIV,
        ST_ROUND,
        ST_DONE
    } state_t;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_PHASE_STEP = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE  = 3'd1;
    localparam logic [2:0] REG_DELAY      = 3'd2;
    localparam logic [2:0] REG_TONE       = 3'd3;
    localparam logic [2:0] REG_RAMP       = 3'd4;

    localparam int AMP_BITS = 16;
    localparam int OUT_BITS = 16;

endpackage

`default_nettype wire

### rtl/rtbg_sine_rom.sv
// Quarter-wave sine ROM with registered read, built at elaboration.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module rtbg_sine_rom #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [SINE_TABLE_BITS:0]   addr,
    output logic [SAMPLE_BITS-2:0]     data
);

    localparam int RW   = SAMPLE_BITS - 1;
    localparam int QTR  = 1 << SINE_TABLE_BITS;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] FULL_SCALE  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    // (2n)(2n+1) for the Taylor terms n = 1..8
    localparam logic [7:0][8:0] DIVISOR = {9'd272, 9'd210, 9'd156, 9'd110,
                                           9'd72, 9'd42, 9'd20, 9'd6};

    typedef logic [QTR:0][RW-1:0] rom_t;

    function automatic rom_t build_rom();
        rom_t               tbl;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        tbl = '0;
        for (int k = 0; k <= QTR; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'(DIVISOR[n-1]);
                if ((n & 1) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            v = ($unsigned(sum) * FULL_SCALE + (64'd1 << 29)) >> 30;
            if (v > FULL_SCALE)
                v = FULL_SCALE;
            tbl[k] = RW'(v);
        end
        return tbl;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [RW-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### rtl/rtbg_serial_mul.sv
// Shift-add multiplier: one multiplier bit per cycle.
// Depends on rtbg_pkg for the unit status struct.
`timescale 1ns / 1ps
`default_nettype none

module rtbg_serial_mul #(
    parameter int A_BITS = 31,
    parameter int B_BITS = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [A_BITS-1:0]         a,
    input  logic [B_BITS-1:0]         b,
    output logic [A_BITS+B_BITS-1:0]  prod,
    output rtbg_pkg::unit_stat_t      stat
);
    import rtbg_pkg::*;

    localparam int P_BITS = A_BITS + B_BITS;
    localparam int CNT_W  = $clog2(B_BITS);

    logic [A_BITS-1:0] a_reg;
    logic [P_BITS-1:0] p_reg;
    logic [P_BITS-1:0] p_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [A_BITS:0]   sum;
    logic              last_step;

    // Add into the upper half, then shift the multiplier bits out at the bottom
    assign sum       = {1'b0, p_reg[P_BITS-1:B_BITS]} + (p_reg[0] ? {1'b0, a_reg} : '0);
    assign last_step = (cnt_reg == CNT_W'(B_BITS - 1));

    always_comb
    begin
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            p_next    = {{A_BITS{1'b0}}, b};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next   = {sum, p_reg[B_BITS-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    assign prod      = p_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### rtl/rtbg_serial_div.sv
// Restoring divider: one quotient bit per cycle.
// The caller guarantees the quotient fits Q_BITS. Depends on rtbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtbg_serial_div #(
    parameter int Q_BITS = 31,
    parameter int H_BITS = 20,
    parameter int D_BITS = 21
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [Q_BITS+H_BITS-1:0]  dividend,
    input  logic [D_BITS-1:0]         divisor,
    output logic [Q_BITS-1:0]         quotient,
    output rtbg_pkg::unit_stat_t      stat
);
    import rtbg_pkg::*;

    localparam int CNT_W = $clog2(Q_BITS);

    logic [D_BITS-1:0] d_reg;
    logic [D_BITS-1:0] rem_reg;
    logic [D_BITS-1:0] rem_next;
    logic [Q_BITS-1:0] q_reg;
    logic [Q_BITS-1:0] q_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [D_BITS:0]   r2;
    logic [D_BITS:0]   diff;
    logic              ge;
    logic              last_step;

    assign r2        = {rem_reg, q_reg[Q_BITS-1]};
    assign diff      = r2 - {1'b0, d_reg};
    assign ge        = (r2 >= {1'b0, d_reg});
    assign last_step = (cnt_reg == CNT_W'(Q_BITS - 1));

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // Upper part is below the divisor, so it seeds the remainder
            rem_next  = D_BITS'(dividend[Q_BITS+H_BITS-1:Q_BITS]);
            q_next    = dividend[Q_BITS-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[D_BITS-1:0] : r2[D_BITS-1:0];
            q_next   = {q_reg[Q_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### rtl/ramped_tone_burst_generator_top.sv
// Ramped tone burst generator: APB registers, burst sequencer and output stage.
// Depends on rtbg_pkg, rtbg_sine_rom, rtbg_serial_mul and rtbg_serial_div.
//
// Usage: every transaction on the s_ stream (s_tdata[0] = restart) is one
// sample tick and yields exactly one transaction on the m_ stream
// (m_tdata = signed sample, m_tlast = final sample of the burst).
// A burst is delay_samples zeros followed by tone_samples sine samples with
// optional linear on/off ramps; the tick after the last sample, or a tick
// with restart set, starts the next burst.
// One tick is worked at a time; s_tready is high only while the sequencer
// is idle. A lead-in sample goes from SETUP straight to DONE. A tone sample
// is scaled by the amplitude in BW = max(COUNT_BITS, 16) steps of the serial
// multiplier, and each active ramp adds one serial multiply plus an MW-step
// restoring divide (MW = SAMPLE_BITS + 15). Results land in an output register;
// a stalled receiver holds the result and the sequencer waits in its final
// state until the register frees up. Reset clears the registers to their
// defaults and the burst position to 0. Registers are written over APB at
// byte address 4*index; pready is tied high.
`timescale 1ns / 1ps
`default_nettype none

module ramped_tone_burst_generator_top #(
    parameter int COUNT_BITS      = 20,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample (signed Q1.15)
    output logic        m_tlast
);
    import rtbg_pkg::*;

    localparam int CW  = COUNT_BITS;
    localparam int STB = SINE_TABLE_BITS;
    localparam int RW  = SAMPLE_BITS - 1;
    localparam int MW  = RW + AMP_BITS;
    localparam int BW  = (COUNT_BITS > AMP_BITS) ? COUNT_BITS : AMP_BITS;

    localparam logic [32:0] DELAY_MAX = (33'd1 << CW) - 33'd1;
    localparam logic [32:0] LEN_MAX   = 33'd1 << CW;
    localparam logic [STB:0] QTR      = (STB + 1)'(1) << STB;
    localparam logic [14:0] MAG_MAX   = 15'h7FFF;

    // configuration registers
    logic [31:0] phase_step_reg;
    logic [15:0] amplitude_reg;
    logic [19:0] delay_reg;
    logic [20:0] tone_reg;
    logic [20:0] ramp_reg;
    logic        cfg_wr;

    // sequencer and burst state
    state_t        state_reg;
    state_t        state_next;
    logic [CW:0]   sample_index_reg;
    logic [CW:0]   sample_index_next;
    logic [31:0]   phase_acc_reg;
    logic [31:0]   phase_acc_next;

    // per-sample working registers
    logic [CW:0]   pos_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] rem_reg;
    logic          lead_reg;
    logic          last_reg;
    logic          up_reg;
    logic          dn_reg;
    logic          neg_reg;
    logic [MW-1:0] m_reg;
    logic [15:0]   result_reg;

    // output register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [15:0]   out_sample_reg;
    logic          out_last_reg;

    // saturated lengths
    logic [32:0]   delay_wide;
    logic [32:0]   tone_wide;
    logic [32:0]   ramp_wide;
    logic [CW-1:0] delay_sat;
    logic [CW:0]   tone_sat;
    logic [CW:0]   ramp_sat;
    logic [CW+1:0] burst_end;

    logic          accept;
    logic          wrap;
    logic [CW+1:0] setup_diff;
    logic          lead;
    logic [CW:0]   rem_w;
    logic          is_last;
    logic [CW:0]   pos_inc;
    logic [STB+1:0] ph_top;
    logic [STB:0]  rom_addr;
    logic          rom_en;
    logic [RW-1:0] rom_data;

    logic          mul_start;
    logic [MW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [MW+BW-1:0] mul_prod;
    unit_stat_t    mul_stat;
    logic          div_start;
    logic [MW-1:0] div_q;
    unit_stat_t    div_stat;
    logic          out_load;

    logic [MW:0]   rnd;
    logic [MW:0]   mag_w;
    logic [14:0]   mag;
    logic [15:0]   result_next;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[4:2])
            REG_PHASE_STEP: prdata = phase_step_reg;
            REG_AMPLITUDE:  prdata = 32'(amplitude_reg);
            REG_DELAY:      prdata = 32'(delay_reg);
            REG_TONE:       prdata = 32'(tone_reg);
            REG_RAMP:       prdata = 32'(ramp_reg);
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= 32'd0;
            amplitude_reg  <= 16'd0;
            delay_reg      <= 20'd0;
            tone_reg       <= 21'd1;
            ramp_reg       <= 21'd0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_PHASE_STEP: phase_step_reg <= pwdata;
                REG_AMPLITUDE:  amplitude_reg  <= pwdata[15:0];
                REG_DELAY:      delay_reg      <= pwdata[19:0];
                REG_TONE:       tone_reg       <= pwdata[20:0];
                REG_RAMP:       ramp_reg       <= pwdata[20:0];
                default:        ;
            endcase
        end
    end

    // clamp lengths to what the counters hold
    assign delay_wide = 33'(delay_reg);
    assign tone_wide  = (tone_reg == 21'd0) ? 33'd1 : 33'(tone_reg);
    assign ramp_wide  = 33'(ramp_reg);
    assign delay_sat  = (delay_wide > DELAY_MAX) ? CW'(DELAY_MAX) : CW'(delay_wide);
    assign tone_sat   = (tone_wide > LEN_MAX) ? (CW + 1)'(LEN_MAX) : (CW + 1)'(tone_wide);
    assign ramp_sat   = (ramp_wide > LEN_MAX) ? (CW + 1)'(LEN_MAX) : (CW + 1)'(ramp_wide);
    assign burst_end  = (CW + 2)'(delay_sat) + (CW + 2)'(tone_sat);

    // ---------------- per-sample index arithmetic ----------------
    assign accept     = s_tvalid && s_tready;
    assign wrap       = s_tdata[0] || ({1'b0, sample_index_reg} >= burst_end);
    assign setup_diff = {1'b0, pos_reg} - (CW + 2)'(delay_sat);
    assign lead       = setup_diff[CW+1];
    assign rem_w      = tone_sat - (CW + 1)'(1) - (CW + 1)'(i_reg);
    assign is_last    = (rem_w == '0);
    assign pos_inc    = pos_reg + (CW + 1)'(1);

    // quadrant folding of the phase
    assign ph_top   = phase_acc_reg[31 -: STB + 2];
    assign rom_addr = ph_top[STB] ? (QTR - {1'b0, ph_top[STB-1:0]})
                                  : {1'b0, ph_top[STB-1:0]};

    always_comb
    begin
        sample_index_next = sample_index_reg;
        phase_acc_next    = phase_acc_reg;
        if (accept && wrap)
        begin
            phase_acc_next = 32'd0;
        end
        else if (state_reg == ST_SETUP && lead)
        begin
            sample_index_next = pos_inc;
            phase_acc_next    = 32'd0;
        end
        else if (state_reg == ST_INDEX)
        begin
            sample_index_next = is_last ? '0 : pos_inc;
            phase_acc_next    = is_last ? 32'd0 : phase_acc_reg + phase_step_reg;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SETUP;
            ST_SETUP:  state_next = lead ? ST_DONE : ST_INDEX;
            ST_INDEX:  state_next = ST_ROM;
            ST_ROM:    state_next = ST_AMP;
            ST_AMP:    if (mul_stat.done) state_next = ST_CHK_UP;
            ST_CHK_UP: state_next = up_reg ? ST_UP_MUL : ST_CHK_DN;
            ST_UP_MUL: if (mul_stat.done) state_next = ST_UP_DIV;
            ST_UP_DIV: if (div_stat.done) state_next = ST_CHK_DN;
            ST_CHK_DN: state_next = dn_reg ? ST_DN_MUL : ST_ROUND;
            ST_DN_MUL: if (mul_stat.done) state_next = ST_DN_DIV;
            ST_DN_DIV: if (div_stat.done) state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        rom_en    = (state_reg == ST_INDEX);
        mul_start = (state_reg == ST_ROM)
                 || (state_reg == ST_CHK_UP && up_reg)
                 || (state_reg == ST_CHK_DN && dn_reg);
        div_start = (state_reg == ST_UP_MUL || state_reg == ST_DN_MUL) && mul_stat.done;
        out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    always_comb
    begin
        mul_a = (state_reg == ST_ROM) ? MW'(rom_data) : m_reg;
        case (state_reg)
            ST_ROM:    mul_b = BW'(amplitude_reg);
            ST_CHK_UP: mul_b = BW'(i_reg);
            default:   mul_b = BW'(rem_reg);
        endcase
    end

    // round half up, drop SAMPLE_BITS, saturate, apply sign
    assign rnd         = (MW + 1)'(m_reg) + ((MW + 1)'(1) << (SAMPLE_BITS - 1));
    assign mag_w       = rnd >> SAMPLE_BITS;
    assign mag         = (mag_w > (MW + 1)'(MAG_MAX)) ? MAG_MAX : mag_w[14:0];
    assign result_next = neg_reg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_index_reg <= '0;
            phase_acc_reg    <= 32'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sample_index_reg <= sample_index_next;
            phase_acc_reg    <= phase_acc_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= wrap ? '0 : sample_index_reg;
        end
        if (state_reg == ST_SETUP)
        begin
            lead_reg <= lead;
            i_reg    <= setup_diff[CW-1:0];
            if (lead)
            begin
                result_reg <= 16'd0;
                last_reg   <= 1'b0;
            end
        end
        if (state_reg == ST_INDEX)
        begin
            rem_reg  <= rem_w[CW-1:0];
            last_reg <= is_last;
            up_reg   <= (ramp_sat != '0) && ((CW + 1)'(i_reg) < ramp_sat);
            neg_reg  <= ph_top[STB+1];
        end
        if (state_reg == ST_ROM)
        begin
            dn_reg <= (ramp_sat != '0) && ((CW + 1)'(rem_reg) < ramp_sat);
        end
        if (state_reg == ST_AMP && mul_stat.done)
        begin
            m_reg <= mul_prod[MW-1:0];
        end
        if ((state_reg == ST_UP_DIV || state_reg == ST_DN_DIV) && div_stat.done)
        begin
            m_reg <= div_q;
        end
        if (state_reg == ST_ROUND)
        begin
            result_reg <= result_next;
        end
        if (out_load)
        begin
            out_sample_reg <= result_reg;
            out_last_reg   <= last_reg;
        end
    end

    // ---------------- datapath units ----------------
    rtbg_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (rom_en),
        .addr (rom_addr),
        .data (rom_data)
    );

    rtbg_serial_mul #(
        .A_BITS (MW),
        .B_BITS (BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .stat  (mul_stat)
    );

    rtbg_serial_div #(
        .Q_BITS (MW),
        .H_BITS (BW),
        .D_BITS (CW + 1)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (ramp_sat),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    // multiplier and divider are chained, never overlapped
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    // no new tick is taken while arithmetic is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_stat.busy || div_stat.busy) |-> !s_tready)
        else $error("input accepted while a unit is busy");

    // a final sample leaves the burst position and phase cleared
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && last_reg) |-> (sample_index_reg == '0 && phase_acc_reg == 32'd0))
        else $error("burst state not cleared after final sample");

    // lead-in samples are silent and never final
    a_lead_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && lead_reg) |-> (result_reg == 16'd0 && !last_reg))
        else $error("lead-in sample not zero");

endmodule

`default_nettype wire

### dv/ramped_tone_burst_generator_checker.sv
// Checker for the ramped tone burst generator: tracks APB writes, predicts one
// sample per accepted tick and compares it against the output stream.
// Depends on rtbg_pkg for the register indexes.
`timescale 1ns / 1ps

module ramped_tone_burst_generator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] sample (signed Q1.15)
    input  logic        m_tlast,
    output int          failures,
    output int          pending,
    output int          results_seen,
    output int          bursts_done,
    output int          tone_seen
);

    import rtbg_pkg::*;

    localparam int                CNT_W     = 20;
    localparam int                TBL_W     = 10;
    localparam int                SMP_W     = 16;
    localparam int                QTR       = 1 << TBL_W;
    localparam longint unsigned   CNT_MAX   = 64'd1 << CNT_W;
    localparam longint unsigned   FULL      = (64'd1 << (SMP_W - 1)) - 1;
    localparam longint unsigned   HALF_PI   = 64'd1686629713;   // pi/2 in Q30

    typedef struct packed {
        logic [15:0] level;
        logic        is_last;
    } tone_sample_t;

    logic [15:0]  sine_q [0:QTR];
    logic [31:0]  cfg_step;
    logic [15:0]  cfg_amp;
    logic [19:0]  cfg_delay;
    logic [20:0]  cfg_tone;
    logic [20:0]  cfg_ramp;
    logic [20:0]  burst_pos;
    logic [31:0]  phase_acc;
    tone_sample_t due_samples [$];
    tone_sample_t got;

    // Quarter-wave sine in Q1.15 from a truncated Q30 Taylor series
    function automatic void build_sine_table();
        longint unsigned x;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        for (int k = 0; k <= QTR; k++)
        begin
            x    = (HALF_PI * 64'(k)) >> TBL_W;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            v = ($unsigned(acc) * FULL + (64'd1 << 29)) >> 30;
            if (v > FULL)
                v = FULL;
            sine_q[k] = 16'(v);
        end
    endfunction

    initial
    begin
        build_sine_table();
    end

    task automatic report_mismatch(input string what);
        failures++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Advance the burst by one tick and queue the sample it produces
    task automatic next_burst_sample(input logic restart);
        longint unsigned lead;
        longint unsigned len;
        longint unsigned rmp;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned rem;
        longint unsigned mag;
        logic [1:0]      quad;
        logic [10:0]     addr;
        tone_sample_t    want;
        lead = cfg_delay;
        len  = (cfg_tone == 0) ? 1 : cfg_tone;
        if (len > CNT_MAX)
            len = CNT_MAX;
        rmp = (cfg_ramp > CNT_MAX) ? CNT_MAX : cfg_ramp;
        pos = burst_pos;
        want = '0;
        // a position left beyond the burst end by a register change restarts too
        if (restart || pos >= lead + len)
        begin
            pos = 0;
            phase_acc = '0;
        end
        if (pos < lead)
        begin
            phase_acc = '0;
        end
        else
        begin
            idx  = pos - lead;
            rem  = len - 1 - idx;
            quad = phase_acc[31:30];
            addr = {1'b0, phase_acc[29:20]};
            if (quad[0])
                addr = 11'(QTR) - addr;
            mag = 64'(sine_q[addr]) * 64'(cfg_amp);
            if (rmp != 0 && idx < rmp)
                mag = (mag * idx) / rmp;
            if (rmp != 0 && rem < rmp)
                mag = (mag * rem) / rmp;
            mag = (mag + (64'd1 << (SMP_W - 1))) >> SMP_W;
            if (mag > 32767)
                mag = 32767;
            want.level   = quad[1] ? 16'(64'd0 - mag) : 16'(mag);
            want.is_last = (rem == 0);
            phase_acc    = phase_acc + cfg_step;
            tone_seen++;
        end
        if (want.is_last)
        begin
            burst_pos = '0;
            phase_acc = '0;
        end
        else
        begin
            burst_pos = 21'(pos + 1);
        end
        due_samples.push_back(want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_step  = '0;
            cfg_amp   = '0;
            cfg_delay = '0;
            cfg_tone  = 21'd1;
            cfg_ramp  = '0;
            burst_pos = '0;
            phase_acc = '0;
            due_samples.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_PHASE_STEP: cfg_step  = pwdata;
                    REG_AMPLITUDE:  cfg_amp   = pwdata[15:0];
                    REG_DELAY:      cfg_delay = pwdata[19:0];
                    REG_TONE:       cfg_tone  = pwdata[20:0];
                    REG_RAMP:       cfg_ramp  = pwdata[20:0];
                    default: ;
                endcase
            end
            // compare before queuing: a tick never yields its sample at the same edge
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tlast === 1'b1)
                    bursts_done++;
                if (due_samples.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected sample %0d last %b",
                                              $signed(m_tdata), m_tlast));
                end
                else
                begin
                    got = due_samples.pop_front();
                    if (m_tdata !== got.level)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                                                  $signed(m_tdata), $signed(got.level)));
                    if (m_tlast !== got.is_last)
                        report_mismatch($sformatf("last %b, expected %b (sample %0d)",
                                                  m_tlast, got.is_last, $signed(got.level)));
                end
            end
            if (s_tvalid && s_tready)
                next_burst_sample(s_tdata[0]);
            pending = due_samples.size();
        end
    end

endmodule

### dv/ramped_tone_burst_generator_top_tb.sv
// Testbench top for the ramped tone burst generator: clock, reset, APB
// programming, tick stimulus with random idling and the final verdict.
// Depends on rtbg_pkg, ramped_tone_burst_generator_top and the checker module.
`timescale 1ns / 1ps

module ramped_tone_burst_generator_top_tb;

    import rtbg_pkg::*;

    localparam int TICKS_WANTED = 1300;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] sample (signed Q1.15)
    logic        m_tlast;

    int failures;
    int pending;
    int results_seen;
    int bursts_done;
    int tone_seen;

    int   ticks_sent;
    int   settings_done;
    int   stuck;
    int   hold_left;
    logic steady;
    logic sink_hold_req;
    logic hold_taken;

    ramped_tone_burst_generator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ramped_tone_burst_generator_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .failures     (failures),
        .pending      (pending),
        .results_seen (results_seen),
        .bursts_done  (bursts_done),
        .tone_seen    (tone_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random back-pressure, or a long hold-off on request
    initial
    begin
        m_tready   = 1'b0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= steady || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Watchdog: give up after a long run of cycles without any transaction
    initial
    begin
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                stuck = 0;
            else
                stuck++;
        end
        $display("ramped_tone_burst_generator_top test failed");
        $finish;
    end

    // All tasks start and end at a falling edge
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_burst(input logic [31:0] step_val, input logic [31:0] amp_val,
                                 input logic [31:0] lead, input logic [31:0] tone_len,
                                 input logic [31:0] ramp_len);
        reg_write(REG_PHASE_STEP, step_val);
        reg_write(REG_AMPLITUDE, amp_val);
        reg_write(REG_DELAY, lead);
        reg_write(REG_TONE, tone_len);
        reg_write(REG_RAMP, ramp_len);
        apb_release();
        settings_done++;
    endtask

    task automatic program_random_burst();
        logic [31:0] step_val;
        logic [31:0] amp_val;
        int unsigned lead;
        int unsigned tone_len;
        int unsigned ramp_len;
        case ($urandom_range(0, 5))
            0:       step_val = 32'd0;
            1:       step_val = 32'hFFFF_FFFF;
            2:       step_val = $urandom_range(0, 32'h0200_0000);
            default: step_val = $urandom();
        endcase
        case ($urandom_range(0, 4))
            0:       amp_val = 32'd0;
            1:       amp_val = 32'h0000_FFFF;
            default: amp_val = $urandom_range(0, 16'hFFFF);
        endcase
        tone_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
        lead     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        case ($urandom_range(0, 3))
            0:       ramp_len = 0;
            1:       ramp_len = tone_len + $urandom_range(0, 3);
            default: ramp_len = $urandom_range(1, (tone_len == 0) ? 1 : tone_len);
        endcase
        program_burst(step_val, amp_val, lead, tone_len, ramp_len);
    endtask

    task automatic send_tick(input logic restart);
        while (!steady && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Drop valid and hold until every predicted sample has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        steady        = 1'b0;
        sink_hold_req = 1'b0;
        ticks_sent    = 0;
        settings_done = 0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;

        // reset values: every tick is a silent one-sample burst
        send_tick(1'b0);
        send_tick(1'b1);
        wait_drained();

        // full-scale step and amplitude, zero tone length behaves as one sample
        program_burst(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd2, 32'd0, 32'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_drained();

        // quarter-cycle steps walk all quadrants; on and off ramps overlap
        program_burst(32'h4000_0000, 32'h0000_FFFF, 32'd0, 32'd6, 32'd4);
        send_tick(1'b1);
        repeat (5)
            send_tick(1'b0);
        wait_drained();

        // all-ones writes: longest lead-in, oversized tone and ramp saturate
        program_burst(32'h1234_5678, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();
        reg_write(REG_DELAY, 32'd0);
        apb_release();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_drained();

        // shrink the burst under a running position: the next tick restarts
        program_burst(32'h0800_0000, 32'h0000_7FFF, 32'd5, 32'd10, 32'd3);
        send_tick(1'b1);
        repeat (6)
            send_tick(1'b0);
        wait_drained();
        reg_write(REG_TONE, 32'd2);
        reg_write(REG_DELAY, 32'd1);
        apb_release();
        send_tick(1'b0);
        send_tick(1'b0);
        wait_drained();

        phase = 0;
        while (ticks_sent < TICKS_WANTED)
        begin
            program_random_burst();
            steady = (phase >= 8 && phase < 12);
            if (phase == 3)
                sink_hold_req = 1'b1;
            n = $urandom_range(20, 60);
            for (int j = 0; j < n; j++)
            begin
                if (phase == 5 && j == n / 2)
                    wait_drained();
                send_tick($urandom_range(0, 99) < 3);
            end
            wait_drained();
            phase++;
        end
        steady = 1'b0;

        repeat (200)
            @(negedge clk);
        $display("covered %0d ticks over %0d register settings: %0d tone samples, %0d bursts",
                 results_seen, settings_done, tone_seen, bursts_done);
        if (failures == 0)
            $display("ramped_tone_burst_generator_top test passed");
        else
            $display("ramped_tone_burst_generator_top test failed");
        $finish;
    end

endmodule

### files.f
rtl/rtbg_pkg.sv
rtl/rtbg_sine_rom.sv
rtl/rtbg_serial_mul.sv
rtl/rtbg_serial_div.sv
rtl/ramped_tone_burst_generator_top.sv
dv/ramped_tone_burst_generator_checker.sv
dv/ramped_tone_burst_generator_top_tb.sv
